// ----- hdl/vfpf_pkg.sv -----
package vfpf_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned CELL_W  = 20;
  localparam int unsigned KEY_W   = 3 * CELL_W;
  localparam int unsigned PROD_W  = COORD_W + INV_W;
  localparam int unsigned NUM_W   = 16;

  localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_axis;
    logic       sat_en;
    logic [1:0] sat_axis;
    logic       scan_start;
    logic       scan_run;
    logic       commit;
  } vfpf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } vfpf_stat_t;

endpackage

// ----- hdl/vfpf_ctrl.sv -----
module vfpf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  vfpf_pkg::vfpf_stat_t stat,
  output vfpf_pkg::vfpf_cmd_t  cmd,
  output logic                 idle
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    idle      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
        if (in_fire) begin
          state_nxt = ST_MUL;
          step_nxt  = 2'd0;
        end
      end
      ST_MUL: begin
        // multiply one axis per step, saturate the previous product
        cmd.mul_en   = (step_r != 2'd3);
        cmd.mul_axis = step_r;
        cmd.sat_en   = (step_r != 2'd0);
        cmd.sat_axis = step_r - 2'd1;
        step_nxt     = step_r + 2'd1;
        if (step_r == 2'd3) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/vfpf_datapath.sv -----
module vfpf_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_POINTS  = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vfpf_pkg::vfpf_cmd_t                   cmd,
  output vfpf_pkg::vfpf_stat_t                  stat,
  input  logic [vfpf_pkg::INV_W-1:0]            inv_res,
  input  logic [3*vfpf_pkg::COORD_W-1:0]        in_coords,
  input  logic                                  in_new_cloud,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [79:0]                           out_data,
  output logic [1:0]                            out_flags
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned PC_W = $clog2(MAX_POINTS);
  localparam int unsigned CW   = vfpf_pkg::CELL_W;

  logic [3*vfpf_pkg::COORD_W-1:0] coords_r;
  logic [vfpf_pkg::PROD_W-1:0]    prod_r;
  logic                           neg_r;
  logic [CW-1:0]                  cell_r [3];
  logic [vfpf_pkg::KEY_W-1:0]     mem [TABLE_DEPTH];
  logic [vfpf_pkg::KEY_W-1:0]     rdata_r;
  logic [AW:0]                    used_r, addr_r;
  logic                           pend_r, found_r;
  logic [PC_W-1:0]                pcnt_r;
  logic                           ovalid_r;
  logic [79:0]                    odata_r;
  logic [1:0]                     oflags_r;

  logic [vfpf_pkg::COORD_W-1:0] sel, mag;
  logic                         sel_neg;
  logic [vfpf_pkg::INV_W-1:0]   q, qs;
  logic [CW-1:0]                cell_v;
  logic [vfpf_pkg::KEY_W-1:0]   key;
  logic [PC_W+15:0]             pnum_ext;
  logic                         hit, table_full;

  always_comb begin
    unique case (cmd.mul_axis)
      vfpf_pkg::AXIS_X: sel = coords_r[31:0];
      vfpf_pkg::AXIS_Y: sel = coords_r[63:32];
      default:          sel = coords_r[95:64];
    endcase
    sel_neg = sel[31];
    mag     = sel_neg ? (~sel + 32'd1) : sel;
    q       = prod_r[vfpf_pkg::PROD_W-1:vfpf_pkg::COORD_W];
    if (neg_r) begin
      qs     = (q > 24'd524288) ? 24'd524288 : q;
      cell_v = ~qs[CW-1:0] + 20'd1;
    end else begin
      qs     = (q > 24'd524287) ? 24'd524287 : q;
      cell_v = qs[CW-1:0];
    end
  end

  assign key        = {cell_r[0], cell_r[1], cell_r[2]};
  assign hit        = pend_r && (rdata_r == key);
  assign table_full = (used_r == (AW+1)'(TABLE_DEPTH));
  assign pnum_ext   = {16'd0, pcnt_r};

  assign stat.scan_done = found_r || (!pend_r && (addr_r >= used_r));
  assign stat.out_free  = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) coords_r <= in_coords;
    if (cmd.mul_en) begin
      prod_r <= mag * inv_res;
      neg_r  <= sel_neg;
    end
    if (cmd.sat_en) begin
      unique case (cmd.sat_axis)
        vfpf_pkg::AXIS_X: cell_r[0] <= cell_v;
        vfpf_pkg::AXIS_Y: cell_r[1] <= cell_v;
        default:          cell_r[2] <= cell_v;
      endcase
    end
    if (cmd.scan_run && (addr_r < used_r)) rdata_r <= mem[addr_r[AW-1:0]];
    if (cmd.commit && !found_r && !table_full) mem[used_r[AW-1:0]] <= key;
    if (cmd.commit) begin
      odata_r  <= {4'd0, cell_r[2], cell_r[1], cell_r[0], pnum_ext[15:0]};
      oflags_r <= {!found_r && table_full, !found_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      pcnt_r   <= '0;
      addr_r   <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.load && in_new_cloud) begin
        used_r <= '0;
        pcnt_r <= '0;
      end
      if (cmd.scan_start) begin
        addr_r  <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end
      if (cmd.scan_run) begin
        pend_r <= (addr_r < used_r) && !found_r && !hit;
        if (addr_r < used_r) addr_r <= addr_r + 1'b1;
        if (hit) found_r <= 1'b1;
      end
      if (cmd.commit) begin
        if (!found_r && !table_full) used_r <= used_r + 1'b1;
        pcnt_r <= (pcnt_r == PC_W'(MAX_POINTS - 1)) ? '0 : pcnt_r + 1'b1;
      end
      if (cmd.commit) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign out_flags = oflags_r;

endmodule

// ----- hdl/voxel_first_point_filter_core.sv -----
// Voxel first-point filter.
// Input stream: one point per word. in_tdata carries coord_x, coord_y, coord_z
// (signed Q16.16), in_tuser carries new_cloud, which clears the seen-voxel
// table and the point counter before that point is handled.
// Output stream: one word per input point, in arrival order. out_tdata carries
// point_number and the saturated voxel indices, out_tuser carries keep and
// table_full. keep is high for any point whose voxel is not in the table.
// cfg_we/cfg_wdata write inv_resolution (unsigned Q8.16); write only while idle.
// Flow: a point passes through the shared multiplier (one axis per cycle,
// each product saturated in the cycle after), then a linear scan of the stored
// keys at one memory read per cycle, then a commit, then the idle state that
// accepts the next word. The scan covers the N voxels stored so far in the
// cloud (up to TABLE_DEPTH); a hit ends the scan early.
// One point is in work at a time; in_tready is high only between points.
// The output register lets the next point be accepted while a result waits;
// a stalled receiver holds the result and the next point stops at commit.
// Reset clears the fill count, the point counter and the output valid and
// loads inv_resolution with 1.0; it takes effect at once, no clearing pass.
module voxel_first_point_filter_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_POINTS  = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // coord_x, coord_y, coord_z
  input  logic        in_tuser,  // new_cloud
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata, // point_number, cell_x, cell_y, cell_z, zero pad
  output logic [1:0]  out_tuser, // keep, table_full
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  vfpf_pkg::vfpf_cmd_t  cmd;
  vfpf_pkg::vfpf_stat_t stat;
  logic                 idle;
  logic [23:0]          inv_res_r;

  // hold the inverse resolution register
  always_ff @(posedge clk) begin
    if (!rst_n) inv_res_r <= vfpf_pkg::INV_RESET;
    else if (cfg_we) inv_res_r <= cfg_wdata;
  end

  assign in_tready = idle;

  vfpf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && idle),
    .stat    (stat),
    .cmd     (cmd),
    .idle    (idle)
  );

  vfpf_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_POINTS  (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .inv_res      (inv_res_r),
    .in_coords    (in_tdata),
    .in_new_cloud (in_tuser),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata),
    .out_flags    (out_tuser)
  );

endmodule
